/* rtl/core/psrc_pkg.sv */
package psrc_pkg;

    // Phase fraction bits and derived frame length
    localparam int FRAC_BITS  = 13;
    localparam int PHASE_W    = 19;
    localparam int MAX_REPEAT = 64;
    localparam int CNT_W      = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
    localparam int LANES      = 2;

    // Field and register widths
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 18;
    localparam int REM_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int START_W    = 13;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [PHASE_W-1:0] FRAME_LEN = PHASE_W'(1) << FRAC_BITS;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_REM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_DEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_PHASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE = 3'd5;

    // Channel modes
    localparam logic [MODE_W-1:0] MODE_MONO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEREO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COPY   = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Rate settings used by the phase sequencer
    typedef struct packed {
        logic [STEP_W-1:0]  step_size;
        logic [REM_W-1:0]   rate_remainder;
        logic [REM_W-1:0]   rate_denominator;
        logic [START_W-1:0] start_phase;
    } t_rate_cfg;

    // Sequencer status toward the top level
    typedef struct packed {
        logic busy;
        logic emit;
        logic last;
    } t_emit_ctl;

endpackage

/* rtl/core/point_sample_rate_converter_unit.sv */
// Nearest-neighbor sample rate converter with Q4.12 gain. Each source frame
// (sample_a, sample_b, restart) transferred in produces zero to 64 output
// frames, one per cycle while the output side is not stalled; the last one
// for a source frame carries last_for_frame. When a frame is taken, its
// samples are scaled in parallel lanes, and the phase sequencer then issues
// its outputs, or only rebases the phase when the frame yields none; no new
// frame is taken while the sequencer is busy. The next
// frame is taken in the cycle after the last output is handed to the output
// register. Configuration writes are to be made only while no frame is in
// progress.
module point_sample_rate_converter_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic        [psrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [psrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [psrc_pkg::SAMPLE_W-1:0]   i_sample_a,
    input  logic signed [psrc_pkg::SAMPLE_W-1:0]   i_sample_b,
    input  logic                                   i_restart,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [psrc_pkg::SAMPLE_W-1:0]   o_out_a,
    output logic signed [psrc_pkg::SAMPLE_W-1:0]   o_out_b,
    output logic                                   o_last_for_frame
);

    localparam int SW = psrc_pkg::SAMPLE_W;

    psrc_pkg::t_rate_cfg               r_cfg;
    logic [psrc_pkg::GAIN_W-1:0]       r_gain;
    logic [psrc_pkg::MODE_W-1:0]       r_mode;
    psrc_pkg::t_emit_ctl               w_ctl;

    logic                              w_accept;
    logic                              w_slot_free;
    logic signed [SW-1:0]              w_lane_in  [psrc_pkg::LANES];
    logic signed [SW-1:0]              w_lane_out [psrc_pkg::LANES];
    logic signed [SW-1:0]              w_out_b;

    logic                              r_out_valid;
    logic signed [SW-1:0]              r_out_a;
    logic signed [SW-1:0]              r_out_b;
    logic                              r_out_last;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size        <= psrc_pkg::STEP_W'(8192);
            r_cfg.rate_remainder   <= '0;
            r_cfg.rate_denominator <= psrc_pkg::REM_W'(1);
            r_cfg.start_phase      <= '0;
            r_gain                 <= psrc_pkg::GAIN_W'(4096);
            r_mode                 <= psrc_pkg::MODE_STEREO;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psrc_pkg::REG_STEP_SIZE:
                    r_cfg.step_size <= i_cfg_data[psrc_pkg::STEP_W-1:0];
                psrc_pkg::REG_RATE_REM:
                    r_cfg.rate_remainder <= i_cfg_data[psrc_pkg::REM_W-1:0];
                psrc_pkg::REG_RATE_DEN:
                    r_cfg.rate_denominator <= i_cfg_data[psrc_pkg::REM_W-1:0];
                psrc_pkg::REG_GAIN:
                    r_gain <= i_cfg_data[psrc_pkg::GAIN_W-1:0];
                psrc_pkg::REG_START_PHASE:
                    r_cfg.start_phase <= i_cfg_data[psrc_pkg::START_W-1:0];
                psrc_pkg::REG_CHANNEL_MODE:
                    r_mode <= i_cfg_data[psrc_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall  = w_ctl.busy;
    assign w_accept    = i_in_valid && !w_ctl.busy;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Scale lanes, one per channel
    assign w_lane_in[0] = i_sample_a;
    if (psrc_pkg::LANES > 1) begin : g_lane_b_in
        assign w_lane_in[1] = i_sample_b;
    end

    for (genvar g = 0; g < psrc_pkg::LANES; g++) begin : g_lane
        psrc_scale_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (w_accept),
            .i_sample (w_lane_in[g]),
            .i_gain   (r_gain),
            .o_scaled (w_lane_out[g])
        );
    end

    // Merge lanes according to channel mode
    if (psrc_pkg::LANES > 1) begin : g_merge
        always_comb begin
            case (r_mode)
                psrc_pkg::MODE_STEREO: w_out_b = w_lane_out[1];
                psrc_pkg::MODE_COPY:   w_out_b = w_lane_out[0];
                default:               w_out_b = '0;
            endcase
        end
    end else begin : g_merge_mono
        assign w_out_b = '0;
    end

    psrc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_restart   (i_restart),
        .i_slot_free (w_slot_free),
        .i_cfg       (r_cfg),
        .o_ctl       (w_ctl)
    );

    // Output register: load on emit, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_out_a    <= w_lane_out[0];
            r_out_b    <= w_out_b;
            r_out_last <= w_ctl.last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_a          = r_out_a;
    assign o_out_b          = r_out_b;
    assign o_last_for_frame = r_out_last;

endmodule

/* rtl/core/psrc_scale_lane.sv */
module psrc_scale_lane (
    input  logic                                  i_clk,
    input  logic                                  i_load,
    input  logic signed [psrc_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic        [psrc_pkg::GAIN_W-1:0]    i_gain,
    output logic signed [psrc_pkg::SAMPLE_W-1:0]  o_scaled
);

    localparam int PROD_W = psrc_pkg::SAMPLE_W + psrc_pkg::GAIN_W + 1;
    localparam int Q_W    = PROD_W + 1 - 12;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W:0]   w_rounded;
    logic signed [Q_W-1:0]    w_quot;

    // Capture the product when a frame is transferred in
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= i_sample * $signed({1'b0, i_gain});
        end
    end

    // Round half up, floor by 4096, then saturate to 16 bits
    always_comb begin
        w_rounded = $signed({r_prod[PROD_W-1], r_prod}) + (PROD_W+1)'(2048);
        w_quot    = Q_W'(w_rounded >>> 12);
        if (w_quot > $signed(Q_W'(32767))) begin
            o_scaled = 16'sh7fff;
        end else if (w_quot < -$signed(Q_W'(32768))) begin
            o_scaled = -16'sh8000;
        end else begin
            o_scaled = w_quot[psrc_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

/* rtl/core/psrc_emit.sv */
module psrc_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_restart,
    input  logic                 i_slot_free,
    input  psrc_pkg::t_rate_cfg  i_cfg,
    output psrc_pkg::t_emit_ctl  o_ctl
);

    localparam int PW = psrc_pkg::PHASE_W;
    localparam int RW = psrc_pkg::REM_W;

    psrc_pkg::t_state                r_state, n_state;
    logic [PW-1:0]                   r_phase, n_phase;
    logic [RW-1:0]                   r_mod, n_mod;
    logic [psrc_pkg::CNT_W-1:0]      r_cnt, n_cnt;

    logic                            w_in_frame;
    logic [PW-1:0]                   w_step_phase;
    logic [PW-1:0]                   w_next_phase;
    logic [RW:0]                     w_rem_sum;
    logic                            w_carry;
    logic [RW-1:0]                   w_next_mod;
    logic                            w_next_in;
    logic                            w_cnt_end;
    logic                            w_emit;
    logic                            w_last;

    // Next phase and remainder after one output
    always_comb begin
        w_in_frame   = (r_phase >> psrc_pkg::FRAC_BITS) == '0;
        w_step_phase = r_phase + PW'(i_cfg.step_size);
        w_rem_sum    = {1'b0, r_mod} + {1'b0, i_cfg.rate_remainder};
        w_carry      = (i_cfg.rate_remainder != '0) &&
                       (w_rem_sum >= {1'b0, i_cfg.rate_denominator});
        w_next_phase = w_step_phase + PW'(w_carry);
        if (i_cfg.rate_remainder == '0) begin
            w_next_mod = r_mod;
        end else if (w_carry) begin
            w_next_mod = RW'(w_rem_sum - {1'b0, i_cfg.rate_denominator});
        end else begin
            w_next_mod = w_rem_sum[RW-1:0];
        end
        w_next_in = (w_next_phase >> psrc_pkg::FRAC_BITS) == '0;
        w_cnt_end = r_cnt == psrc_pkg::CNT_W'(psrc_pkg::MAX_REPEAT - 1);
    end

    // Sequence the outputs of one frame
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_mod   = r_mod;
        n_cnt   = r_cnt;
        w_emit  = 1'b0;
        w_last  = 1'b0;
        case (r_state)
            psrc_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = psrc_pkg::ST_EMIT;
                    n_cnt   = '0;
                    if (i_restart) begin
                        n_phase = PW'(i_cfg.start_phase);
                        n_mod   = '0;
                    end
                end
            end
            psrc_pkg::ST_EMIT: begin
                if (!w_in_frame) begin
                    // Frame already passed: rebase only
                    n_phase = r_phase - psrc_pkg::FRAME_LEN;
                    n_state = psrc_pkg::ST_IDLE;
                end else if (i_slot_free) begin
                    w_emit = 1'b1;
                    w_last = !w_next_in || w_cnt_end;
                    n_mod  = w_next_mod;
                    n_cnt  = r_cnt + 1'b1;
                    if (w_last) begin
                        n_state = psrc_pkg::ST_IDLE;
                        n_phase = w_next_in ? '0 : w_next_phase - psrc_pkg::FRAME_LEN;
                    end else begin
                        n_phase = w_next_phase;
                    end
                end
            end
            default: begin
                n_state = psrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psrc_pkg::ST_IDLE;
            r_phase <= '0;
            r_mod   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_mod   <= n_mod;
            r_cnt   <= n_cnt;
        end
    end

    assign o_ctl.busy = r_state != psrc_pkg::ST_IDLE;
    assign o_ctl.emit = w_emit;
    assign o_ctl.last = w_last;

    // Checks
    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.emit |-> i_slot_free)
        else $error("output produced without a free slot");

    a_idle_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ctl.busy |-> !o_ctl.emit)
        else $error("output produced while idle");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.emit && o_ctl.last |=> !o_ctl.busy)
        else $error("sequencer still busy after last output");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_ctl.busy |=> o_ctl.busy)
        else $error("frame transfer did not start the sequencer");

endmodule
